// ----- rtl/core/palindromic_tree_builder_macros.svh -----
// Assertion macros for the palindromic tree builder.
// Used by palindromic_tree_builder.sv; no other dependencies.
`ifndef PALINDROMIC_TREE_BUILDER_MACROS_SVH
`define PALINDROMIC_TREE_BUILDER_MACROS_SVH
`ifndef SYNTH
`define PTB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ptb assertion failed");
`define PTB_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("ptb sequencing assertion failed");
`else
`define PTB_ASSERT(label, clk, rst_n, prop)
`define PTB_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif
`endif

// ----- rtl/core/ptb_pkg.sv -----
// Package of the palindromic tree builder: field widths and payload types.
// No dependencies.
package ptb_pkg;

    localparam int SYMBOL_W = 8;
    localparam int NODE_W   = 11;
    localparam int LEN_W    = 11;
    localparam int START_W  = 10;
    localparam int OCC_W    = 11;
    localparam int CNT_W    = 11;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node_index;
        logic [LEN_W-1:0]   pal_length;
        logic [START_W-1:0] start_pos;
        logic               is_new;
        logic [OCC_W-1:0]   occurrences;
        logic [CNT_W-1:0]   distinct_count;
        logic               full_res;
    } result_t;

endpackage

// ----- rtl/core/ptb_stream_if.sv -----
// Valid/ready stream interface carrying one payload per transfer.
// Payload type is set by a type parameter; no other dependencies.
interface ptb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/palindromic_tree_builder.sv -----
// Palindromic tree builder: sequencer, node and symbol memories.
// Depends on ptb_pkg, ptb_stream_if and palindromic_tree_builder_macros.svh.
//
// Each accepted symbol is appended and placed in the palindromic tree; one result
// transfer follows per symbol. The block takes one symbol at a time: a suffix-link
// step reads the node, then the symbol, then compares, and skips the symbol read and
// the compare when the candidate would start before the string or the node is the
// odd root. The child search reads node entries one at a time, starting from the
// first non-root node, and a second walk and search run when a new node needs its
// suffix link. The single read port of the node memory and the serial search set
// the pace of each item. A symbol offered once the store is full is taken but not
// stored, and its result has full_res set. The result sits in an output register,
// so the next symbol is taken while it waits.
`include "palindromic_tree_builder_macros.svh"

module palindromic_tree_builder #(
    parameter int MAX_LEN     = 1024,
    parameter int SYMBOL_BITS = 8
) (
    input  logic clk,
    input  logic rst_n,
    ptb_stream_if.sink   symbols,
    ptb_stream_if.source results
);
    localparam int DEPTH = MAX_LEN + 2;
    localparam int NW    = $clog2(DEPTH);
    localparam int NTW   = $clog2(DEPTH + 1);
    localparam int PW    = $clog2(MAX_LEN);
    localparam int SLW   = $clog2(MAX_LEN + 1);
    localparam int LW    = SLW + 1;
    localparam int SB    = SYMBOL_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_WRD, S_WLEN, S_WSYM, S_WEND, S_SRD, S_SCHK,
        S_SEND, S_NEW, S_ORD, S_FULL, S_DONE
    } state_t;

    state_t state_reg;

    logic [SB-1:0]  sym_reg;
    logic [PW-1:0]  pos_reg;
    logic [SLW-1:0] strlen_reg;
    logic [NTW-1:0] nodetot_reg;
    logic [NW-1:0]  lsn_reg;
    logic [NW-1:0]  k_reg;
    logic [LW-1:0]  lenk_reg;
    logic [NW-1:0]  suf_reg;
    logic           second_reg;
    logic [NTW-1:0] scan_reg;
    logic           found_reg;
    logic [NW-1:0]  pk_reg;
    logic [LW-1:0]  plen_reg;
    ptb_pkg::result_t res_reg;
    ptb_pkg::result_t out_reg;
    logic           out_valid_reg;

    // Memories and their registered read data.
    logic [SB-1:0]            sym_mem  [MAX_LEN];
    logic [LW-1:0]            len_mem  [DEPTH];
    logic [NW-1:0]            suf_mem  [DEPTH];
    logic [NW-1:0]            par_mem  [DEPTH];
    logic [SB-1:0]            edge_mem [DEPTH];
    logic [ptb_pkg::OCC_W-1:0] occ_mem [DEPTH];
    logic [PW-1:0]            st_mem   [DEPTH];

    logic [SB-1:0]            rd_sym;
    logic [LW-1:0]            rd_len;
    logic [NW-1:0]            rd_suf;
    logic [NW-1:0]            rd_par;
    logic [SB-1:0]            rd_edge;
    logic [ptb_pkg::OCC_W-1:0] rd_occ;
    logic [PW-1:0]            rd_st;

    logic [31:0]    sym_ext;
    logic [SB-1:0]  sym_in;
    logic           accept;
    logic           store_full;
    logic [NW-1:0]  node_raddr;
    logic [PW-1:0]  sym_raddr;
    logic [LW-1:0]  len_cur;
    logic [NW-1:0]  suf_cur;
    logic [LW:0]    ival;
    logic [NW-1:0]  new_node;
    logic [LW-1:0]  new_len;
    logic [PW-1:0]  new_start;
    logic [NTW-1:0] nodetot_inc;
    logic [ptb_pkg::OCC_W-1:0] occ_inc;
    logic           we_node;
    logic           we_occ;
    logic [NW-1:0]  occ_waddr;

    assign sym_ext    = {24'b0, symbols.data.symbol};
    assign sym_in     = sym_ext[SB-1:0];
    assign accept     = symbols.valid && symbols.ready;
    assign store_full = strlen_reg == SLW'(MAX_LEN);

    assign symbols.ready = state_reg == S_IDLE;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    // Roots live outside the memory: node 0 has length -1, node 1 length 0 and
    // a link to node 0.
    always_comb
    begin
        if (k_reg == NW'(0))
        begin
            len_cur = '1;
            suf_cur = '0;
        end
        else if (k_reg == NW'(1))
        begin
            len_cur = '0;
            suf_cur = '0;
        end
        else
        begin
            len_cur = rd_len;
            suf_cur = rd_suf;
        end
    end

    assign ival = (LW+1)'(pos_reg) - {len_cur[LW-1], len_cur} - (LW+1)'(1);

    assign new_len     = plen_reg + LW'(2);
    assign new_start   = PW'((LW+1)'(strlen_reg) - (LW+1)'(new_len));
    assign new_node    = (nodetot_reg >= NTW'(DEPTH)) ? NW'(DEPTH - 1) : nodetot_reg[NW-1:0];
    assign nodetot_inc = (nodetot_reg >= NTW'(DEPTH)) ? nodetot_reg : nodetot_reg + NTW'(1);
    assign occ_inc     = rd_occ + ptb_pkg::OCC_W'(1);

    assign we_node   = state_reg == S_NEW;
    assign we_occ    = (state_reg == S_NEW) || (state_reg == S_ORD);
    assign occ_waddr = (state_reg == S_NEW) ? new_node : scan_reg[NW-1:0];

    always_comb
    begin
        unique case (state_reg)
            S_WRD:          node_raddr = k_reg;
            S_SRD, S_SEND:  node_raddr = scan_reg[NW-1:0];
            default:        node_raddr = '0;
        endcase
    end

    assign sym_raddr = ival[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && !store_full)
        begin
            sym_mem[strlen_reg[PW-1:0]] <= sym_in;
        end
        rd_sym <= sym_mem[sym_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we_node)
        begin
            len_mem[new_node]  <= new_len;
            suf_mem[new_node]  <= found_reg && second_reg ? scan_reg[NW-1:0] : NW'(1);
            par_mem[new_node]  <= pk_reg;
            edge_mem[new_node] <= sym_reg;
            st_mem[new_node]   <= new_start;
        end
        if (we_occ)
        begin
            occ_mem[occ_waddr] <= (state_reg == S_NEW) ? ptb_pkg::OCC_W'(1) : occ_inc;
        end
        rd_len  <= len_mem[node_raddr];
        rd_suf  <= suf_mem[node_raddr];
        rd_par  <= par_mem[node_raddr];
        rd_edge <= edge_mem[node_raddr];
        rd_occ  <= occ_mem[node_raddr];
        rd_st   <= st_mem[node_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            strlen_reg    <= '0;
            nodetot_reg   <= NTW'(2);
            lsn_reg       <= '0;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            // In S_DONE the output register is reloaded below instead.
            if (out_valid_reg && results.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (store_full)
                        begin
                            state_reg <= S_FULL;
                        end
                        else
                        begin
                            sym_reg    <= sym_in;
                            pos_reg    <= strlen_reg[PW-1:0];
                            strlen_reg <= strlen_reg + SLW'(1);
                            k_reg      <= lsn_reg;
                            second_reg <= 1'b0;
                            state_reg  <= S_WRD;
                        end
                    end
                end
                S_WRD:
                begin
                    if (NTW'(k_reg) >= nodetot_reg)
                    begin
                        k_reg     <= '0;
                        lenk_reg  <= '1;
                        suf_reg   <= '0;
                        state_reg <= S_WEND;
                    end
                    else
                    begin
                        state_reg <= S_WLEN;
                    end
                end
                S_WLEN:
                begin
                    lenk_reg <= len_cur;
                    suf_reg  <= suf_cur;
                    // The odd root always matches, so the walk ends there.
                    if (len_cur[LW-1])
                    begin
                        state_reg <= S_WEND;
                    end
                    else if (ival[LW])
                    begin
                        k_reg     <= suf_cur;
                        state_reg <= S_WRD;
                    end
                    else
                    begin
                        state_reg <= S_WSYM;
                    end
                end
                S_WSYM:
                begin
                    if (rd_sym == sym_reg)
                    begin
                        state_reg <= S_WEND;
                    end
                    else
                    begin
                        k_reg     <= suf_reg;
                        state_reg <= S_WRD;
                    end
                end
                S_WEND:
                begin
                    scan_reg  <= NTW'(2);
                    state_reg <= S_SRD;
                end
                S_SRD:
                begin
                    if (scan_reg >= nodetot_reg)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_SEND;
                    end
                    else
                    begin
                        state_reg <= S_SCHK;
                    end
                end
                S_SCHK:
                begin
                    if (rd_par == k_reg && rd_edge == sym_reg)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_SEND;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + NTW'(1);
                        state_reg <= S_SRD;
                    end
                end
                S_SEND:
                begin
                    if (second_reg)
                    begin
                        state_reg <= S_NEW;
                    end
                    else if (found_reg)
                    begin
                        state_reg <= S_ORD;
                    end
                    else
                    begin
                        pk_reg   <= k_reg;
                        plen_reg <= lenk_reg;
                        // A length-one node links to the even root directly.
                        if (lenk_reg[LW-1])
                        begin
                            state_reg <= S_NEW;
                        end
                        else
                        begin
                            k_reg      <= suf_reg;
                            second_reg <= 1'b1;
                            state_reg  <= S_WRD;
                        end
                    end
                end
                S_NEW:
                begin
                    nodetot_reg            <= nodetot_inc;
                    lsn_reg                <= new_node;
                    res_reg.node_index     <= ptb_pkg::NODE_W'(new_node);
                    res_reg.pal_length     <= ptb_pkg::LEN_W'(new_len);
                    res_reg.start_pos      <= ptb_pkg::START_W'(new_start);
                    res_reg.is_new         <= 1'b1;
                    res_reg.occurrences    <= ptb_pkg::OCC_W'(1);
                    res_reg.distinct_count <= ptb_pkg::CNT_W'(nodetot_inc - NTW'(2));
                    res_reg.full_res       <= 1'b0;
                    state_reg              <= S_DONE;
                end
                S_ORD:
                begin
                    lsn_reg                <= scan_reg[NW-1:0];
                    res_reg.node_index     <= ptb_pkg::NODE_W'(scan_reg);
                    res_reg.pal_length     <= ptb_pkg::LEN_W'(rd_len);
                    res_reg.start_pos      <= ptb_pkg::START_W'(rd_st);
                    res_reg.is_new         <= 1'b0;
                    res_reg.occurrences    <= occ_inc;
                    res_reg.distinct_count <= ptb_pkg::CNT_W'(nodetot_reg - NTW'(2));
                    res_reg.full_res       <= 1'b0;
                    state_reg              <= S_DONE;
                end
                S_FULL:
                begin
                    res_reg                <= '0;
                    res_reg.distinct_count <= ptb_pkg::CNT_W'(nodetot_reg - NTW'(2));
                    res_reg.full_res       <= 1'b1;
                    state_reg              <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || results.ready)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PTB_ASSERT(a_strlen_bound, clk, rst_n, strlen_reg <= SLW'(MAX_LEN))
    `PTB_ASSERT(a_node_bound, clk, rst_n, (NTW+1)'(nodetot_reg) <= (NTW+1)'(strlen_reg) + (NTW+1)'(2))
    `PTB_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != S_IDLE)
    `PTB_ASSERT(a_flags_exclusive, clk, rst_n, out_valid_reg |-> !(out_reg.is_new && out_reg.full_res))

endmodule
